[rtl/core/scan_disk_scheduler_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the SCAN disk scheduler
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH
`define SCAN_DISK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define SDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sds check failed");

// next-cycle implication
`define SDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sds check failed");

`endif

[rtl/core/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants of the SCAN disk scheduler.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int CYL_W            = 16;
  localparam int DIST_W           = 17;
  localparam int CFG_IDX_W        = 2;
  localparam int DEF_MAX_REQUESTS = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = 1;
  localparam int QCNT_W           = 2;

  localparam logic [CYL_W-1:0] TOP_RESET  = 16'd4999;
  localparam logic [CYL_W-1:0] HEAD_RESET = 16'd143;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_CYLINDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_POSITION = 2'd1;

  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic             last;
  } sds_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_UP,
    ST_TOP,
    ST_DOWN
  } sds_state_t;

endpackage

[rtl/core/sds_ifs.sv]
// ----------------------------------------------------------------------------
// sds_in_if / sds_out_if
// Valid/ready channels for requests and served cylinders.
// ----------------------------------------------------------------------------
interface sds_in_if;
  logic                    valid;
  logic                    ready;
  logic [sds_pkg::CYL_W-1:0] request_cylinder;
  logic                    last_request;

  modport source (output valid, output request_cylinder, output last_request, input ready);
  modport sink   (input valid, input request_cylinder, input last_request, output ready);
endinterface

interface sds_out_if;
  logic                       valid;
  logic                       ready;
  logic [sds_pkg::CYL_W-1:0]  served_cylinder;
  logic [sds_pkg::DIST_W-1:0] total_distance;
  logic                       end_of_schedule;

  modport source (output valid, output served_cylinder, output total_distance,
                  output end_of_schedule, input ready);
  modport sink   (input valid, input served_cylinder, input total_distance,
                  input end_of_schedule, output ready);
endinterface

[rtl/core/sds_front.sv]
// ----------------------------------------------------------------------------
// sds_front
// Accepts requests, clamps them to the top cylinder and queues them.
// ----------------------------------------------------------------------------
module sds_front (
  input  logic                      clk,
  input  logic                      rst_n,
  sds_in_if.sink                    in_ch,
  input  logic [sds_pkg::CYL_W-1:0] top_cyl,
  output logic                      item_valid,
  input  logic                      item_ready,
  output sds_pkg::sds_item_t        item
);

  sds_pkg::sds_item_t               q_r [sds_pkg::QUEUE_DEPTH];
  logic [sds_pkg::QPTR_W-1:0]       wr_r, wr_nxt;
  logic [sds_pkg::QPTR_W-1:0]       rd_r, rd_nxt;
  logic [sds_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  sds_pkg::sds_item_t               push_item;
  logic                             push;
  logic                             pop;

  assign in_ch.ready = (cnt_r != sds_pkg::QCNT_W'(sds_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (cnt_r != '0);
  assign pop         = item_valid && item_ready;
  assign item        = q_r[rd_r];

  always_comb begin
    push_item.cyl  = (in_ch.request_cylinder > top_cyl) ? top_cyl : in_ch.request_cylinder;
    push_item.last = in_ch.last_request;
  end

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_item;
    end
  end

endmodule

[rtl/core/sds_back.sv]
// ----------------------------------------------------------------------------
// sds_back
// Sorts queued requests into a row of cells and plays out the SCAN order.
// ----------------------------------------------------------------------------
module sds_back #(
  parameter int MAX_REQUESTS = sds_pkg::DEF_MAX_REQUESTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  sds_pkg::sds_item_t         item,
  input  logic [sds_pkg::CYL_W-1:0]  top_cyl,
  input  logic [sds_pkg::CYL_W-1:0]  head_pos,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sds_pkg::CYL_W-1:0]  served_cylinder,
  output logic [sds_pkg::DIST_W-1:0] total_distance,
  output logic                       end_of_schedule
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  sds_pkg::sds_state_t          state_r, state_nxt;
  logic [sds_pkg::CYL_W-1:0]    cells_r [MAX_REQUESTS];
  logic [sds_pkg::CYL_W-1:0]    cells_nxt [MAX_REQUESTS];
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             ptr_r, ptr_nxt;
  logic [CNT_W-1:0]             first_up_r, first_up_nxt;
  logic [sds_pkg::DIST_W-1:0]   dist_r, dist_nxt;
  logic                         out_valid_r;
  logic [sds_pkg::CYL_W-1:0]    out_cyl_r;
  logic [sds_pkg::DIST_W-1:0]   out_dist_r;
  logic                         out_eos_r;

  logic [MAX_REQUESTS-1:0]      gt;
  logic [MAX_REQUESTS-1:0]      gt_prev;
  logic [sds_pkg::CYL_W-1:0]    head_c;
  logic [CNT_W-1:0]             rd_ptr;
  logic [sds_pkg::CYL_W-1:0]    rd_val;
  logic                         slot_free;
  logic                         ptr_lt_n;
  logic                         search_go;
  logic                         ins;
  logic                         emit;
  logic [sds_pkg::CYL_W-1:0]    emit_cyl;
  logic [sds_pkg::DIST_W-1:0]   emit_dist;
  logic                         emit_eos;
  logic                         batch_done;

  assign head_c    = (head_pos > top_cyl) ? top_cyl : head_pos;
  assign slot_free = !out_valid_r || out_ready;
  assign ptr_lt_n  = (ptr_r < count_r);
  assign rd_ptr    = (state_r == sds_pkg::ST_DOWN) ? ptr_r - CNT_ONE : ptr_r;
  assign rd_val    = cells_r[rd_ptr[IDX_W-1:0]];
  assign search_go = ptr_lt_n && (rd_val < head_c);
  assign ins       = item_valid && item_ready && (count_r != CNT_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sds_pkg::ST_LOAD: begin
        if (item_valid && item.last) begin
          state_nxt = sds_pkg::ST_SEARCH;
        end
      end
      sds_pkg::ST_SEARCH: begin
        if (!search_go) begin
          state_nxt = sds_pkg::ST_UP;
        end
      end
      sds_pkg::ST_UP: begin
        if (!ptr_lt_n) begin
          state_nxt = sds_pkg::ST_TOP;
        end
      end
      sds_pkg::ST_TOP: begin
        if (slot_free) begin
          state_nxt = (first_up_r == '0) ? sds_pkg::ST_LOAD : sds_pkg::ST_DOWN;
        end
      end
      sds_pkg::ST_DOWN: begin
        if (slot_free && (ptr_r == CNT_ONE)) begin
          state_nxt = sds_pkg::ST_LOAD;
        end
      end
      default: state_nxt = sds_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    item_ready = 1'b0;
    emit       = 1'b0;
    emit_cyl   = rd_val;
    emit_dist  = '0;
    emit_eos   = 1'b0;
    batch_done = 1'b0;
    unique case (state_r)
      sds_pkg::ST_LOAD: begin
        item_ready = 1'b1;
      end
      sds_pkg::ST_SEARCH: begin
      end
      sds_pkg::ST_UP: begin
        emit = slot_free && ptr_lt_n;
      end
      sds_pkg::ST_TOP: begin
        emit       = slot_free;
        emit_cyl   = top_cyl;
        emit_eos   = (first_up_r == '0);
        emit_dist  = emit_eos ? dist_r : '0;
        batch_done = slot_free && emit_eos;
      end
      sds_pkg::ST_DOWN: begin
        emit       = slot_free;
        emit_eos   = (ptr_r == CNT_ONE);
        emit_dist  = emit_eos ? dist_r : '0;
        batch_done = slot_free && emit_eos;
      end
      default: begin
      end
    endcase
  end

  // insertion into the sorted row
  always_comb begin
    for (int j = 0; j < MAX_REQUESTS; j++) begin
      gt[j] = (CNT_W'(j) < count_r) && (cells_r[j] > item.cyl);
    end
    gt_prev[0] = 1'b0;
    for (int j = 1; j < MAX_REQUESTS; j++) begin
      gt_prev[j] = gt[j-1];
    end
    for (int j = 0; j < MAX_REQUESTS; j++) begin
      cells_nxt[j] = cells_r[j];
      if (ins && (gt[j] || (CNT_W'(j) == count_r))) begin
        cells_nxt[j] = item.cyl;
      end
    end
    for (int j = 1; j < MAX_REQUESTS; j++) begin
      if (ins && gt_prev[j]) begin
        cells_nxt[j] = cells_r[j-1];
      end
    end
  end

  // sequencing counters
  always_comb begin
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    first_up_nxt = first_up_r;
    dist_nxt     = dist_r;
    if (ins) begin
      count_nxt = count_r + CNT_ONE;
    end
    if (batch_done) begin
      count_nxt = '0;
    end
    case (state_r)
      sds_pkg::ST_LOAD: begin
        ptr_nxt = '0;
      end
      sds_pkg::ST_SEARCH: begin
        if (search_go) begin
          ptr_nxt = ptr_r + CNT_ONE;
        end else begin
          first_up_nxt = ptr_r;
          dist_nxt = {1'b0, top_cyl} - {1'b0, head_c};
          if (ptr_r != '0) begin
            dist_nxt = dist_nxt + ({1'b0, top_cyl} - {1'b0, cells_r[0]});
          end
        end
      end
      sds_pkg::ST_UP: begin
        if (emit) begin
          ptr_nxt = ptr_r + CNT_ONE;
        end
      end
      sds_pkg::ST_TOP: begin
        if (emit) begin
          ptr_nxt = first_up_r;
        end
      end
      sds_pkg::ST_DOWN: begin
        if (emit) begin
          ptr_nxt = ptr_r - CNT_ONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sds_pkg::ST_LOAD;
      count_r     <= '0;
      ptr_r       <= '0;
      first_up_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ptr_r      <= ptr_nxt;
      first_up_r <= first_up_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    dist_r  <= dist_nxt;
    if (emit) begin
      out_cyl_r  <= emit_cyl;
      out_dist_r <= emit_dist;
      out_eos_r  <= emit_eos;
    end
  end

  assign out_valid       = out_valid_r;
  assign served_cylinder = out_cyl_r;
  assign total_distance  = out_dist_r;
  assign end_of_schedule = out_eos_r;

endmodule

[rtl/core/scan_disk_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit
// SCAN (elevator) ordering of one batch of cylinder requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per item; last_request closes the batch.
//   Requests above top_cylinder are clamped; requests past MAX_REQUESTS are
//   dropped. out_ch returns the requests at or above the head in ascending
//   order, then the top stop, then the lower requests in descending order.
//   The final result has end_of_schedule set and carries total_distance.
// Timing:
//   A two-entry queue takes one request per cycle while it is not full; the sorter
//   absorbs one per cycle while loading, so a batch loads at one request per cycle.
//   After the last request the sorter steps past the requests below the head
//   to the first at or above it, then emits one result per cycle while the
//   output is free, with an idle step between the upward pass and the top stop.
//   It accepts no new batch until the final result is in the output register.
// Reset: rst_n (synchronous) empties the queue and batch and restores
//   top_cylinder to 4999 and head_position to 143.
// Stall: a low out_ch.ready holds the output register and pauses emission;
//   the queue keeps taking requests until it fills.
// Config: cfg_index 0 is top_cylinder, 1 is head_position; write when idle.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit #(
  parameter int MAX_REQUESTS = sds_pkg::DEF_MAX_REQUESTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sds_in_if.sink                        in_ch,
  sds_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sds_pkg::CYL_W-1:0]     cfg_wdata
);

  logic [sds_pkg::CYL_W-1:0] top_cyl_r;
  logic [sds_pkg::CYL_W-1:0] head_pos_r;
  logic                      item_valid;
  logic                      item_ready;
  sds_pkg::sds_item_t        item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_cyl_r  <= sds_pkg::TOP_RESET;
      head_pos_r <= sds_pkg::HEAD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sds_pkg::REG_TOP_CYLINDER) begin
        top_cyl_r <= cfg_wdata;
      end else if (cfg_index == sds_pkg::REG_HEAD_POSITION) begin
        head_pos_r <= cfg_wdata;
      end
    end
  end

  sds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .top_cyl    (top_cyl_r),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  sds_back #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .top_cyl         (top_cyl_r),
    .head_pos        (head_pos_r),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .served_cylinder (out_ch.served_cylinder),
    .total_distance  (out_ch.total_distance),
    .end_of_schedule (out_ch.end_of_schedule)
  );

endmodule

[rtl/core/sds_checker.sv]
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks on the result channel of the SCAN scheduler.
// ----------------------------------------------------------------------------
`include "scan_disk_scheduler_unit_assert.svh"

module sds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sds_pkg::CYL_W-1:0]  served_cylinder,
  input logic [sds_pkg::DIST_W-1:0] total_distance,
  input logic                       end_of_schedule
);

  `SDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(served_cylinder) && $stable(total_distance) && $stable(end_of_schedule))
  `SDS_ASSERT_NOW(a_dist_final_only, out_valid && !end_of_schedule, total_distance == '0)
  `SDS_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid)

endmodule

bind scan_disk_scheduler_unit sds_checker u_sds_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .served_cylinder (out_ch.served_cylinder),
  .total_distance  (out_ch.total_distance),
  .end_of_schedule (out_ch.end_of_schedule)
);

[sim/sds_schedule_checker.sv]
// ----------------------------------------------------------------------------
// sds_schedule_checker
// Watches the request, result and register ports of the SCAN disk scheduler.
// It keeps its own copy of the registers and the sorted batch, works out the
// service order each time a batch closes, and compares every result field by
// field with the oldest outstanding entry.
// ----------------------------------------------------------------------------
module sds_schedule_checker #(
  parameter int MAX_REQ = sds_pkg::DEF_MAX_REQUESTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sds_in_if                             in_ch,
  sds_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sds_pkg::CYL_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [sds_pkg::CYL_W-1:0]  cyl;
    logic [sds_pkg::DIST_W-1:0] travel_len;
    logic                       eos;
  } visit_t;

  logic [sds_pkg::CYL_W-1:0] top_cyl;
  logic [sds_pkg::CYL_W-1:0] head_pos;
  logic [sds_pkg::CYL_W-1:0] batch [MAX_REQ];
  int                        batch_len;
  visit_t                    visit_q [$];
  visit_t                    want;
  int                        errs;

  task automatic add_visit(input logic [sds_pkg::CYL_W-1:0] cyl,
                           input logic [sds_pkg::DIST_W-1:0] travel_len,
                           input logic eos);
    visit_t v;
    v.cyl        = cyl;
    v.travel_len = travel_len;
    v.eos        = eos;
    visit_q.push_back(v);
  endtask

  task automatic take_request(input logic [sds_pkg::CYL_W-1:0] req, input logic closes);
    logic [sds_pkg::CYL_W-1:0]  c;
    logic [sds_pkg::CYL_W-1:0]  head;
    logic [sds_pkg::DIST_W-1:0] travel;
    int                         pos;
    int                         first_up;
    int                         i;
    c = (req > top_cyl) ? top_cyl : req;
    if (batch_len < MAX_REQ) begin
      pos = batch_len;
      while (pos > 0 && batch[pos-1] > c) begin
        batch[pos] = batch[pos-1];
        pos--;
      end
      batch[pos] = c;
      batch_len++;
    end
    if (closes) begin
      head = (head_pos > top_cyl) ? top_cyl : head_pos;
      first_up = 0;
      while (first_up < batch_len && batch[first_up] < head) first_up++;
      travel = sds_pkg::DIST_W'(top_cyl - head);
      if (first_up > 0) travel = travel + sds_pkg::DIST_W'(top_cyl - batch[0]);
      for (i = first_up; i < batch_len; i++) add_visit(batch[i], '0, 1'b0);
      if (first_up == 0) begin
        add_visit(top_cyl, travel, 1'b1);
      end else begin
        add_visit(top_cyl, '0, 1'b0);
        for (i = first_up; i > 0; i--)
          add_visit(batch[i-1], (i == 1) ? travel : '0, i == 1);
      end
      batch_len = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      top_cyl   = sds_pkg::TOP_RESET;
      head_pos  = sds_pkg::HEAD_RESET;
      batch_len = 0;
      visit_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (visit_q.size() == 0) begin
          $error("result with none outstanding: served_cylinder %0d", out_ch.served_cylinder);
          errs++;
        end else begin
          want = visit_q.pop_front();
          if (out_ch.served_cylinder !== want.cyl) begin
            $error("served_cylinder: expected %0d, got %0d", want.cyl, out_ch.served_cylinder);
            errs++;
          end
          if (out_ch.total_distance !== want.travel_len) begin
            $error("total_distance: expected %0d, got %0d", want.travel_len,
                   out_ch.total_distance);
            errs++;
          end
          if (out_ch.end_of_schedule !== want.eos) begin
            $error("end_of_schedule: expected %0d, got %0d", want.eos, out_ch.end_of_schedule);
            errs++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) take_request(in_ch.request_cylinder, in_ch.last_request);
      if (cfg_we) begin
        case (cfg_index)
          sds_pkg::REG_TOP_CYLINDER:  top_cyl  = cfg_wdata;
          sds_pkg::REG_HEAD_POSITION: head_pos = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending    <= visit_q.size();
    fail_count <= errs;
  end

endmodule

[sim/scan_disk_scheduler_unit_test.sv]
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit_test
// Drives batches of cylinder requests into the SCAN disk scheduler under
// several register settings, with random gaps on the request side and random
// stalls on the result side. A checker beside the block predicts the service
// order and travel; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit_test;

  localparam logic [sds_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [sds_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int DIRECTED_ITEMS = 28;
  localparam int RANDOM_ITEMS   = 220;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sds_pkg::CYL_W-1:0]     cfg_wdata;
  logic                          steady;
  int                            fail_count;
  int                            pending;
  int                            items_sent;

  sds_in_if  in_ch ();
  sds_out_if out_ch ();

  scan_disk_scheduler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  sds_schedule_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 19);
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_request(input logic [sds_pkg::CYL_W-1:0] cyl, input logic closes);
    steady <= (items_sent >= 120 && items_sent < 180);
    while (!steady && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.request_cylinder <= cyl;
    in_ch.last_request     <= closes;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // drop valid, wait out all results, then let the block go idle
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic load_settings(input logic [sds_pkg::CYL_W-1:0] top,
                               input logic [sds_pkg::CYL_W-1:0] head);
    cfg_we    <= 1'b1;
    cfg_index <= sds_pkg::REG_TOP_CYLINDER;
    cfg_wdata <= top;
    @(posedge clk);
    cfg_index <= sds_pkg::REG_HEAD_POSITION;
    cfg_wdata <= head;
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3;
    cfg_wdata <= sds_pkg::CYL_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [sds_pkg::CYL_W-1:0] pick_cylinder(
      input logic [sds_pkg::CYL_W-1:0] top, input logic [sds_pkg::CYL_W-1:0] head);
    case ($urandom_range(9))
      0:       return head;
      1:       return top;
      2:       return top + 1'b1;
      3:       return head - 1'b1;
      4, 5:    return sds_pkg::CYL_W'($urandom_range(top));
      6:       return head + sds_pkg::CYL_W'($urandom_range(3));
      7:       return sds_pkg::CYL_W'($urandom_range(top, 65535));
      default: return sds_pkg::CYL_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [sds_pkg::CYL_W-1:0] top;
    logic [sds_pkg::CYL_W-1:0] head;
    int                        size;
    int                        k;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = sds_pkg::REG_TOP_CYLINDER;
    cfg_wdata              = '0;
    steady                 = 1'b0;
    items_sent             = 0;
    in_ch.valid            = 1'b0;
    in_ch.request_cylinder = '0;
    in_ch.last_request     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: head and top hits, clamp, both passes, then upward only
    push_request(16'd143, 1'b0);
    push_request(16'd0, 1'b0);
    push_request(16'd4999, 1'b0);
    push_request(16'hFFFF, 1'b0);
    push_request(16'd142, 1'b0);
    push_request(16'd144, 1'b1);
    push_request(16'd2000, 1'b1);
    settle();

    load_settings(16'hFFFF, 16'd0);
    push_request(16'd0, 1'b0);
    push_request(16'hFFFF, 1'b0);
    push_request(16'h5555, 1'b0);
    push_request(16'hAAAA, 1'b1);
    settle();

    // head above top, smallest top, overfull batch closed by a dropped item
    load_settings(16'd1, 16'hFFFF);
    for (k = 1; k <= 17; k++) begin
      case (k % 4)
        0:       push_request(16'd0, k == 17);
        1:       push_request(16'd1, k == 17);
        2:       push_request(16'd2, k == 17);
        default: push_request(16'hFFFF, k == 17);
      endcase
    end
    settle();

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0:       top = 16'd1;
        1:       top = 16'hFFFF;
        2:       top = sds_pkg::CYL_W'($urandom_range(1, 200));
        default: top = sds_pkg::CYL_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(6))
        0:       head = 16'd0;
        1:       head = top;
        2:       head = 16'hFFFF;
        3:       head = sds_pkg::CYL_W'($urandom);
        default: head = sds_pkg::CYL_W'($urandom_range(top));
      endcase
      load_settings(top, head);
      repeat ($urandom_range(1, 3)) begin
        size = ($urandom_range(7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        for (k = 1; k <= size; k++) push_request(pick_cylinder(top, head), k == size);
      end
      settle();
    end

    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
